### hdl/bpr_pkg.sv
// Shared types, widths, codes and helper functions of the bilinear resampler.
package bpr_pkg;

    // Field and register widths
    localparam int OP_W        = 1;
    localparam int DIM_W       = 9;
    localparam int PAD_W       = DIM_W + 1;
    localparam int COORD_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int PIX_W       = 32;
    localparam int CH_W        = 8;
    localparam int CH_N        = PIX_W / CH_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DIM_W;

    // Fixed-point layout: 16 fraction bits, weights from the top 8 of them
    localparam int POS_FRAC_W  = 16;
    localparam int FRAC_W      = 8;
    localparam int STEP_W      = POS_FRAC_W + 1;
    localparam int POS_W       = COORD_W + STEP_W;
    localparam int IMOD_W      = FRAC_W + 1;
    localparam int WT_W        = 2 * FRAC_W + 1;
    localparam int ACC_W       = CH_W + WT_W;
    localparam int DIV_N_W     = DIM_W + POS_FRAC_W;

    // Image store
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Defaults
    localparam int MAX_DIMENSION_DEF = 256;
    localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(256);
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [IMOD_W-1:0] WEIGHT_ONE = IMOD_W'(256);

    // Operation codes
    localparam logic [OP_W-1:0] OP_STORE   = 1'b0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALPHA    = 2'd2;

    // Neighbour codes, in read order
    localparam int NB_N = 4;
    localparam logic [1:0] NB_NW = 2'd0;
    localparam logic [1:0] NB_NE = 2'd1;
    localparam logic [1:0] NB_SW = 2'd2;
    localparam logic [1:0] NB_SE = 2'd3;

    // What an item does at the memory port
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_ERROR,
        KIND_DIRECT,
        KIND_BLEND
    } kind_t;

    // Clamp a size register into 1..cap
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] s,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        if (s == '0)
            r = DIM_W'(1);
        else if (s > cap)
            r = cap;
        else
            r = s;
        return r;
    endfunction

    // Round a size of at least 1 up to a power of two
    function automatic logic [PAD_W-1:0] pad_pow2(input logic [DIM_W-1:0] s);
        logic [DIM_W-1:0] v;
        logic [PAD_W-1:0] p;
        v = s - DIM_W'(1);
        p = PAD_W'(1);
        for (int i = 0; i < DIM_W; i++)
        begin
            if (v[i])
                p = PAD_W'(1) << (i + 1);
        end
        return p;
    endfunction

endpackage

### hdl/bpr_ram.sv
// Generic single-port synchronous RAM with registered read data.
module bpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on we, read the old contents every cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

### hdl/bpr_div.sv
// Bit-serial restoring divider for the position step, one quotient bit a cycle.
module bpr_div #(
    parameter int N_W = 25,
    parameter int D_W = 10,
    parameter int Q_W = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [Q_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   num_reg;
    logic [D_W:0]     rem_reg;
    logic [D_W-1:0]   div_reg;
    logic             zero_reg;
    logic [D_W:0]     rem_shift;
    logic [D_W:0]     rem_diff;
    logic             fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        rem_shift = {rem_reg[D_W-1:0], num_reg[N_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_diff  = rem_shift - {1'b0, div_reg};
    end

    // Count the remaining steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(N_W);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // Load operands, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[N_W-2:0], fits};
            rem_reg <= fits ? rem_diff : rem_shift;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = zero_reg ? '0 : num_reg[Q_W-1:0];

endmodule

### hdl/bilinear_pow2_texture_resampler.sv
// Top level of the bilinear power-of-two resampler: image store and blend pipeline.
//
//  Channel   Signals                                              Handshake
//  --------  ---------------------------------------------------  -----------------------
//  item in   operation source_index source_pixel target_x/y       start & !busy
//  result    result_pixel coordinate_error                        result_valid, 1 cycle
//  config    cfg_index cfg_data                                   cfg_valid & cfg_ready
//
//  A store item, an error item or an unscaled item makes a single access to the single memory
//  port, a blended item one access per neighbour with a nonzero weight: 1, 2 or 4. That port
//  sets the rate.
//  After reset and after each configuration write, busy stays high while the
//  serial dividers form the position steps. The image store is not cleared.
//  The receiver cannot stall: each result is shown for exactly one cycle.
module bilinear_pow2_texture_resampler #(
    parameter int MAX_DIMENSION = bpr_pkg::MAX_DIMENSION_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bpr_pkg::OP_W-1:0]        operation,
    input  logic [bpr_pkg::ADDR_W-1:0]      source_index,
    input  logic [bpr_pkg::PIX_W-1:0]       source_pixel,
    input  logic [bpr_pkg::COORD_W-1:0]     target_x,
    input  logic [bpr_pkg::COORD_W-1:0]     target_y,
    output logic                            result_valid,
    output logic [bpr_pkg::PIX_W-1:0]       result_pixel,
    output logic                            coordinate_error,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bpr_pkg::*;

    localparam int DIM_LIMIT = (1 << DIM_W) - 1;
    localparam int MAX_CAP   = (MAX_DIMENSION < DIM_LIMIT) ? MAX_DIMENSION : DIM_LIMIT;
    localparam logic [DIM_W-1:0] MAX_CAP_V = DIM_W'(MAX_CAP);

    // Configuration and derived geometry
    logic [DIM_W-1:0]  src_w_reg;
    logic [DIM_W-1:0]  src_h_reg;
    logic              keep_alpha_reg;
    logic              recalc_req_reg;
    logic              cfg_write;
    logic [DIM_W-1:0]  clamp_w;
    logic [DIM_W-1:0]  clamp_h;
    logic [PAD_W-1:0]  pad_w_calc;
    logic [PAD_W-1:0]  pad_h_calc;
    logic [DIM_W-1:0]  dim_w_reg;
    logic [PAD_W-1:0]  pad_w_reg;
    logic [PAD_W-1:0]  pad_h_reg;
    logic              direct_reg;
    logic              div_x_busy;
    logic              div_y_busy;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic              recalc_busy;

    // Stage 1: accepted item
    logic               s1_valid_reg;
    logic [OP_W-1:0]    s1_op_reg;
    logic [ADDR_W-1:0]  s1_index_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    logic [COORD_W-1:0] s1_tx_reg;
    logic [COORD_W-1:0] s1_ty_reg;

    // Stage 2: scaled positions
    logic               s2_valid_reg;
    logic [OP_W-1:0]    s2_op_reg;
    logic [ADDR_W-1:0]  s2_index_reg;
    logic [PIX_W-1:0]   s2_pixel_reg;
    logic               s2_err_reg;
    logic [POS_W-1:0]   s2_xpos_reg;
    logic [POS_W-1:0]   s2_ypos_reg;

    // Stage 3: memory port sequencing
    logic               s3_valid_reg;
    kind_t              s3_kind_reg;
    logic [ADDR_W-1:0]  s3_addr_reg;
    logic [PIX_W-1:0]   s3_pixel_reg;
    logic               s3_modx_nz_reg;
    logic               s3_mody_nz_reg;
    logic [WT_W-1:0]    s3_wt_reg [NB_N];
    logic [1:0]         s3_idx_reg;

    // Read tag, aligned with the memory read data
    logic               t_valid_reg;
    kind_t              t_kind_reg;
    logic [WT_W-1:0]    t_wt_reg;
    logic               t_first_reg;
    logic               t_last_reg;
    logic [ACC_W-1:0]   acc_reg [CH_N];

    // Result registers
    logic               result_valid_reg;
    logic [PIX_W-1:0]   result_pixel_reg;
    logic               coordinate_error_reg;

    // Combinational pipeline control and datapath
    logic               accept;
    logic               s1_free;
    logic               s1_adv;
    logic               s2_free;
    logic               s2_adv;
    logic               s3_free;
    logic               s3_done;
    logic [1:0]         s3_last_idx;
    logic [1:0]         s3_next_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIX_W-1:0]   mem_rdata;
    logic               tag_push;
    logic               result_load;
    logic [POS_W-1:0]   xpos_calc;
    logic [POS_W-1:0]   ypos_calc;
    logic               err_calc;
    logic [FRAC_W-1:0]  modx;
    logic [FRAC_W-1:0]  mody;
    logic [IMOD_W-1:0]  imodx;
    logic [IMOD_W-1:0]  imody;
    logic [ADDR_W-1:0]  base_calc;
    logic [WT_W-1:0]    wt_calc [NB_N];
    kind_t              kind_calc;
    logic [ACC_W-1:0]   lane_sum [CH_N];
    logic [PIX_W-1:0]   pixel_calc;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold the registers and flag a step recompute after reset and on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg      <= RESET_DIM;
            src_h_reg      <= RESET_DIM;
            keep_alpha_reg <= 1'b0;
            recalc_req_reg <= 1'b1;
        end
        else
        begin
            recalc_req_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  src_w_reg      <= cfg_data;
                    CFG_SOURCE_HEIGHT: src_h_reg      <= cfg_data;
                    CFG_KEEP_ALPHA:    keep_alpha_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

    // Derive clamped and padded sizes
    always_comb
    begin
        clamp_w    = clamp_dim(src_w_reg, MAX_CAP_V);
        clamp_h    = clamp_dim(src_h_reg, MAX_CAP_V);
        pad_w_calc = pad_pow2(clamp_w);
        pad_h_calc = pad_pow2(clamp_h);
    end

    // Capture geometry when the recompute starts
    always_ff @(posedge clk)
    begin
        if (recalc_req_reg)
        begin
            dim_w_reg  <= clamp_w;
            pad_w_reg  <= pad_w_calc;
            pad_h_reg  <= pad_h_calc;
            direct_reg <= ({1'b0, clamp_w} == pad_w_calc) && ({1'b0, clamp_h} == pad_h_calc);
        end
    end

    // Form the steps ((size-1) << 16) / (padded-1)
    bpr_div #(
        .N_W (DIV_N_W),
        .D_W (PAD_W),
        .Q_W (STEP_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (recalc_req_reg),
        .dividend ({clamp_w - DIM_W'(1), {POS_FRAC_W{1'b0}}}),
        .divisor  (pad_w_calc - PAD_W'(1)),
        .busy     (div_x_busy),
        .quotient (step_x)
    );

    bpr_div #(
        .N_W (DIV_N_W),
        .D_W (PAD_W),
        .Q_W (STEP_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (recalc_req_reg),
        .dividend ({clamp_h - DIM_W'(1), {POS_FRAC_W{1'b0}}}),
        .divisor  (pad_h_calc - PAD_W'(1)),
        .busy     (div_y_busy),
        .quotient (step_y)
    );

    assign recalc_busy = recalc_req_reg || div_x_busy || div_y_busy;

    // ---------------------------------------------------------------
    // Pipeline flow control
    // ---------------------------------------------------------------
    always_comb
    begin
        if (s3_modx_nz_reg && s3_mody_nz_reg)
            s3_last_idx = NB_SE;
        else if (s3_mody_nz_reg)
            s3_last_idx = NB_SW;
        else if (s3_modx_nz_reg)
            s3_last_idx = NB_NE;
        else
            s3_last_idx = NB_NW;

        if (s3_idx_reg == NB_NW && !s3_modx_nz_reg)
            s3_next_idx = NB_SW;
        else
            s3_next_idx = s3_idx_reg + 2'd1;

        s3_done = s3_valid_reg && (s3_kind_reg != KIND_BLEND || s3_idx_reg == s3_last_idx);
        s3_free = !s3_valid_reg || s3_done;
        s2_adv  = s2_valid_reg && s3_free;
        s2_free = !s2_valid_reg || s2_adv;
        s1_adv  = s1_valid_reg && s2_free;
        s1_free = !s1_valid_reg || s1_adv;
    end

    assign busy   = recalc_busy || !s1_free;
    assign accept = start && !busy;

    // Advance the stage valid bits and the neighbour counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_idx_reg   <= NB_NW;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !s1_adv);
            s2_valid_reg <= s1_adv || (s2_valid_reg && !s2_adv);
            s3_valid_reg <= s2_adv || (s3_valid_reg && !s3_done);
            if (s2_adv)
                s3_idx_reg <= NB_NW;
            else if (s3_valid_reg && !s3_done)
                s3_idx_reg <= s3_next_idx;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: hold the accepted item
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= operation;
            s1_index_reg <= source_index;
            s1_pixel_reg <= source_pixel;
            s1_tx_reg    <= target_x;
            s1_ty_reg    <= target_y;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: scale the target into source positions
    // ---------------------------------------------------------------
    always_comb
    begin
        xpos_calc = POS_W'(s1_tx_reg) * POS_W'(step_x);
        ypos_calc = POS_W'(s1_ty_reg) * POS_W'(step_y);
        err_calc  = (PAD_W'(s1_tx_reg) >= pad_w_reg) || (PAD_W'(s1_ty_reg) >= pad_h_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_index_reg <= s1_index_reg;
            s2_pixel_reg <= s1_pixel_reg;
            s2_err_reg   <= err_calc;
            s2_xpos_reg  <= xpos_calc;
            s2_ypos_reg  <= ypos_calc;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3 load: base address, fractions and weights
    // ---------------------------------------------------------------
    always_comb
    begin
        modx  = s2_xpos_reg[POS_FRAC_W-1 -: FRAC_W];
        mody  = s2_ypos_reg[POS_FRAC_W-1 -: FRAC_W];
        imodx = WEIGHT_ONE - IMOD_W'(modx);
        imody = WEIGHT_ONE - IMOD_W'(mody);
        base_calc = ADDR_W'(
            (2 * DIM_W + 1)'(s2_ypos_reg[POS_W-1:POS_FRAC_W]) * (2 * DIM_W + 1)'(dim_w_reg)
            + (2 * DIM_W + 1)'(s2_xpos_reg[POS_W-1:POS_FRAC_W]));
        wt_calc[NB_NW] = WT_W'(imodx * imody);
        wt_calc[NB_NE] = WT_W'(IMOD_W'(modx) * imody);
        wt_calc[NB_SW] = WT_W'(imodx * IMOD_W'(mody));
        wt_calc[NB_SE] = WT_W'(IMOD_W'(modx) * IMOD_W'(mody));
        if (s2_op_reg == OP_STORE)
            kind_calc = KIND_STORE;
        else if (s2_err_reg)
            kind_calc = KIND_ERROR;
        else if (direct_reg)
            kind_calc = KIND_DIRECT;
        else
            kind_calc = KIND_BLEND;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_kind_reg    <= kind_calc;
            s3_addr_reg    <= (s2_op_reg == OP_STORE) ? s2_index_reg : base_calc;
            s3_pixel_reg   <= s2_pixel_reg;
            s3_modx_nz_reg <= (modx != '0);
            s3_mody_nz_reg <= (mody != '0);
            for (int n = 0; n < NB_N; n++)
            begin
                s3_wt_reg[n] <= wt_calc[n];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: drive the memory port, one access per cycle
    // ---------------------------------------------------------------
    always_comb
    begin
        case (s3_idx_reg)
            NB_NW:   rd_addr = s3_addr_reg;
            NB_NE:   rd_addr = s3_addr_reg + ADDR_W'(1);
            NB_SW:   rd_addr = s3_addr_reg + ADDR_W'(dim_w_reg);
            NB_SE:   rd_addr = s3_addr_reg + ADDR_W'(dim_w_reg) + ADDR_W'(1);
            default: rd_addr = s3_addr_reg;
        endcase
        mem_we   = s3_valid_reg && (s3_kind_reg == KIND_STORE);
        mem_addr = mem_we ? s3_addr_reg : rd_addr;
        tag_push = s3_valid_reg && (s3_kind_reg != KIND_STORE);
    end

    bpr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s3_pixel_reg),
        .rdata (mem_rdata)
    );

    // Tag the read so its data meets the right weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else
            t_valid_reg <= tag_push;
    end

    always_ff @(posedge clk)
    begin
        if (tag_push)
        begin
            t_kind_reg  <= s3_kind_reg;
            t_wt_reg    <= s3_wt_reg[s3_idx_reg];
            t_first_reg <= (s3_idx_reg == NB_NW);
            t_last_reg  <= (s3_idx_reg == s3_last_idx);
        end
    end

    // ---------------------------------------------------------------
    // Accumulate weighted channels and compose the result
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            lane_sum[c] = (t_first_reg ? ACC_W'(0) : acc_reg[c])
                        + ACC_W'(mem_rdata[c*CH_W +: CH_W]) * ACC_W'(t_wt_reg);
        end

        pixel_calc = '0;
        case (t_kind_reg)
            KIND_DIRECT:
                pixel_calc = mem_rdata;
            KIND_BLEND:
            begin
                for (int c = 0; c < CH_N; c++)
                begin
                    pixel_calc[c*CH_W +: CH_W] = lane_sum[c][POS_FRAC_W +: CH_W];
                end
                if (!keep_alpha_reg)
                    pixel_calc[PIX_W-1 -: CH_W] = ALPHA_OPAQUE;
            end
            default:
                pixel_calc = '0;
        endcase

        result_load = t_valid_reg && (t_kind_reg != KIND_BLEND || t_last_reg);
    end

    always_ff @(posedge clk)
    begin
        if (t_valid_reg && t_kind_reg == KIND_BLEND)
        begin
            for (int c = 0; c < CH_N; c++)
            begin
                acc_reg[c] <= lane_sum[c];
            end
        end
    end

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_load;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_pixel_reg     <= pixel_calc;
            coordinate_error_reg <= (t_kind_reg == KIND_ERROR);
        end
    end

    assign result_valid     = result_valid_reg;
    assign result_pixel     = result_pixel_reg;
    assign coordinate_error = coordinate_error_reg;

`ifndef SYNTH
    // A result only follows a tagged memory access
    a_result_from_tag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(t_valid_reg))
        else $error("result without a preceding tagged access");

    // An error result carries a zero pixel
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && coordinate_error |-> result_pixel == '0)
        else $error("error result with nonzero pixel");

    // The neighbour counter never runs past the last needed neighbour
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_kind_reg == KIND_BLEND |-> s3_idx_reg <= s3_last_idx)
        else $error("neighbour counter past last neighbour");

    // A configuration write blocks items while the steps are recomputed
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> busy)
        else $error("not busy after configuration write");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for the bilinear power-of-two resampler: directed rows, then random phases.
module tb_top;
    import bpr_pkg::*;

    localparam int MAX_DIM = MAX_DIMENSION_DEF;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 94;
    localparam int RANDOM_PHASE = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [OP_W-1:0]        op;
        logic [ADDR_W-1:0]      idx;
        logic [PIX_W-1:0]       pix;
        logic [COORD_W-1:0]     tx;
        logic [COORD_W-1:0]     ty;
        logic                   known;
        logic [PIX_W-1:0]       known_pix;
        logic                   known_err;
    } stim_row_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             err;
    } pixel_result_t;

    // Per-phase settings: extremes, padded-to-one sizes, clamped sizes, odd sizes
    localparam logic [DIM_W-1:0] PHASE_W [PHASES] =
        '{9'd256, 9'd200, 9'd1, 9'd255, 9'd2, 9'd0, 9'd100, 9'd1, 9'd17, 9'd256, 9'd1, 9'd5};
    localparam logic [DIM_W-1:0] PHASE_H [PHASES] =
        '{9'd256, 9'd150, 9'd1, 9'd255, 9'd3, 9'd511, 9'd1, 9'd100, 9'd33, 9'd129, 9'd1, 9'd7};
    localparam logic PHASE_A [PHASES] =
        '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam int IDLE_PCT [3] = '{19, 62, 0};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OP_W-1:0]        operation;
    logic [ADDR_W-1:0]      source_index;
    logic [PIX_W-1:0]       source_pixel;
    logic [COORD_W-1:0]     target_x;
    logic [COORD_W-1:0]     target_y;
    logic                   result_valid;
    logic [PIX_W-1:0]       result_pixel;
    logic                   coordinate_error;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow of the block: image, registers, outstanding results
    logic [PIX_W-1:0]       image_mem [STORE_DEPTH];
    bit                     written [STORE_DEPTH];
    logic [DIM_W-1:0]       width_q = RESET_DIM;
    logic [DIM_W-1:0]       height_q = RESET_DIM;
    logic                   alpha_q = 1'b0;
    pixel_result_t          pixel_expect [$];
    logic [ADDR_W-1:0]      fetch_addr [NB_N];
    int                     fetch_n;

    stim_row_t              stim_rows [$];
    logic                   known_valid = 1'b0;
    logic [PIX_W-1:0]       known_pix;
    logic                   known_err;
    int                     sender_idle_pct = 0;
    int                     items_sent = 0;
    int                     fail_count = 0;
    int                     stall_cycles = 0;

    bilinear_pow2_texture_resampler #(
        .MAX_DIMENSION(MAX_DIM)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .source_index(source_index),
        .source_pixel(source_pixel),
        .target_x(target_x),
        .target_y(target_y),
        .result_valid(result_valid),
        .result_pixel(result_pixel),
        .coordinate_error(coordinate_error),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Clamp a size register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] s);
        if (s == '0)
            return DIM_W'(1);
        if (s > DIM_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        return s;
    endfunction

    // Round up to the next power of two
    function automatic logic [PAD_W-1:0] pad_dim(input logic [DIM_W-1:0] s);
        logic [PAD_W-1:0] p;
        p = PAD_W'(1);
        while (p < PAD_W'(s))
            p = p << 1;
        return p;
    endfunction

    // Read the image and note the address
    function automatic logic [PIX_W-1:0] take(input logic [ADDR_W-1:0] addr);
        fetch_addr[fetch_n] = addr;
        fetch_n++;
        return image_mem[addr];
    endfunction

    // Predict one output pixel from the shadow image and registers
    function automatic void resample(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty,
                                     output logic [PIX_W-1:0] pix, output logic err);
        logic [DIM_W-1:0]   w, h;
        logic [PAD_W-1:0]   pw, ph;
        logic [24:0]        xstep, ystep, xpos, ypos, acc;
        logic [FRAC_W-1:0]  modx, mody;
        logic [IMOD_W-1:0]  imodx, imody;
        logic [ADDR_W-1:0]  base;
        logic [PIX_W-1:0]   nbr [NB_N];
        logic [24:0]        wt [NB_N];
        w = eff_dim(width_q);
        h = eff_dim(height_q);
        pw = pad_dim(w);
        ph = pad_dim(h);
        pix = '0;
        err = 1'b0;
        fetch_n = 0;
        for (int k = 0; k < NB_N; k++)
            nbr[k] = '0;
        if (PAD_W'(tx) >= pw || PAD_W'(ty) >= ph)
        begin
            err = 1'b1;
            return;
        end
        // Already power-of-two: pass the stored pixel through
        if (PAD_W'(w) == pw && PAD_W'(h) == ph)
        begin
            pix = take(ADDR_W'(32'(ty) * 32'(w) + 32'(tx)));
            return;
        end
        xstep = (pw > PAD_W'(1)) ? (25'(w - 1'b1) << 16) / 25'(pw - 1'b1) : '0;
        ystep = (ph > PAD_W'(1)) ? (25'(h - 1'b1) << 16) / 25'(ph - 1'b1) : '0;
        xpos = 25'(tx) * xstep;
        ypos = 25'(ty) * ystep;
        modx = xpos[15:8];
        mody = ypos[15:8];
        imodx = WEIGHT_ONE - IMOD_W'(modx);
        imody = WEIGHT_ONE - IMOD_W'(mody);
        base = ADDR_W'(32'(ypos[24:16]) * 32'(w) + 32'(xpos[24:16]));
        // Skip neighbours that carry no weight
        nbr[NB_NW] = take(base);
        if (modx != '0)
            nbr[NB_NE] = take(base + 1'b1);
        if (mody != '0)
        begin
            nbr[NB_SW] = take(base + ADDR_W'(w));
            if (modx != '0)
                nbr[NB_SE] = take(base + ADDR_W'(w) + 1'b1);
        end
        wt[NB_NW] = 25'(imodx) * 25'(imody);
        wt[NB_NE] = 25'(modx) * 25'(imody);
        wt[NB_SW] = 25'(imodx) * 25'(mody);
        wt[NB_SE] = 25'(modx) * 25'(mody);
        for (int c = 0; c < CH_N; c++)
        begin
            if (c == CH_N - 1 && !alpha_q)
                pix[c*CH_W +: CH_W] = ALPHA_OPAQUE;
            else
            begin
                acc = '0;
                for (int k = 0; k < NB_N; k++)
                    acc = acc + 25'(nbr[k][c*CH_W +: CH_W]) * wt[k];
                pix[c*CH_W +: CH_W] = acc[23:16];
            end
        end
    endfunction

    // Track accepted items and writes, check each result against the oldest expectation
    always @(posedge clk)
    begin : scoreboard
        pixel_result_t exp_r;
        logic [PIX_W-1:0] p;
        logic e;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pixel_expect.size() == 0)
                begin
                    $error("result_pixel: no item outstanding, got %h", result_pixel);
                    fail_count++;
                end
                else
                begin
                    exp_r = pixel_expect.pop_front();
                    if (result_pixel !== exp_r.pix)
                    begin
                        $error("result_pixel: expected %h, got %h", exp_r.pix, result_pixel);
                        fail_count++;
                    end
                    if (coordinate_error !== exp_r.err)
                    begin
                        $error("coordinate_error: expected %b, got %b", exp_r.err,
                               coordinate_error);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  width_q = cfg_data;
                    CFG_SOURCE_HEIGHT: height_q = cfg_data;
                    CFG_KEEP_ALPHA:    alpha_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (operation == OP_STORE)
                    image_mem[source_index] = source_pixel;
                else if (known_valid)
                    pixel_expect.push_back('{known_pix, known_err});
                else
                begin
                    resample(target_x, target_y, p, e);
                    pixel_expect.push_back('{p, e});
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one item, idling cycle by cycle at the sender rate, and hold it until taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] idx,
                             input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] tx,
                             input logic [COORD_W-1:0] ty);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        operation = op;
        source_index = idx;
        source_pixel = pix;
        target_x = tx;
        target_y = ty;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_STORE)
            written[idx] = 1'b1;
        items_sent++;
        @(negedge clk);
    endtask

    // Store random data into every neighbour the item would read but nobody wrote yet
    task automatic fill_neighbours(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
        logic [PIX_W-1:0] unused_pix;
        logic unused_err;
        logic [ADDR_W-1:0] need [NB_N];
        int n;
        resample(tx, ty, unused_pix, unused_err);
        n = fetch_n;
        for (int k = 0; k < n; k++)
            need[k] = fetch_addr[k];
        for (int k = 0; k < n; k++)
        begin
            if (!written[need[k]])
                send_item(OP_STORE, need[k], $urandom, 8'($urandom), 8'($urandom));
        end
    endtask

    // Drop start and let outstanding results and store traffic settle
    task automatic wait_drained();
        start = 1'b0;
        while (pixel_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        while (busy)
            @(negedge clk);
        cfg_index = ridx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One random item: mostly well-formed computes, some stores anywhere
    task automatic random_item();
        logic [DIM_W-1:0] w, h;
        logic [PAD_W-1:0] pw, ph;
        logic [COORD_W-1:0] tx, ty;
        int pick;
        w = eff_dim(width_q);
        h = eff_dim(height_q);
        pw = pad_dim(w);
        ph = pad_dim(h);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_item(OP_STORE, 16'($urandom), $urandom, 8'($urandom), 8'($urandom));
        else if (pick < 25)
            send_item(OP_STORE, 16'($urandom_range(0, int'(w) * int'(h) - 1)), $urandom,
                      8'($urandom), 8'($urandom));
        else
        begin
            if (pick < 90)
            begin
                tx = 8'($urandom_range(0, int'(pw) - 1));
                ty = 8'($urandom_range(0, int'(ph) - 1));
            end
            else
            begin
                tx = 8'($urandom);
                ty = 8'($urandom);
            end
            fill_neighbours(tx, ty);
            send_item(OP_COMPUTE, 16'($urandom), $urandom, tx, ty);
        end
    endtask

    function automatic stim_row_t store_row(input logic [ADDR_W-1:0] idx,
                                            input logic [PIX_W-1:0] pix);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = OP_STORE;
        r.idx = idx;
        r.pix = pix;
        return r;
    endfunction

    function automatic stim_row_t compute_row(input logic [COORD_W-1:0] tx,
                                              input logic [COORD_W-1:0] ty);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = OP_COMPUTE;
        r.tx = tx;
        r.ty = ty;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [COORD_W-1:0] tx,
                                            input logic [COORD_W-1:0] ty,
                                            input logic [PIX_W-1:0] pix, input logic err);
        stim_row_t r;
        r = compute_row(tx, ty);
        r.known = 1'b1;
        r.known_pix = pix;
        r.known_err = err;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] ridx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CONFIG;
        r.reg_idx = ridx;
        r.reg_val = val;
        return r;
    endfunction

    initial
    begin
        logic [DIM_W-1:0] w_cfg, h_cfg;
        logic a_cfg;
        int first_item;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_STORE;
        source_index = '0;
        source_pixel = '0;
        target_x = '0;
        target_y = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SOURCE_WIDTH;
        cfg_data = '0;

        stim_rows = '{
            // 256 x 256 after reset: stored pixels come back unchanged
            store_row(16'h0000, 32'hFFFF_FFFF),
            store_row(16'hFFFF, 32'h0000_0000),
            store_row(16'h0102, 32'h8040_2010),
            known_row(8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0),
            known_row(8'd255, 8'd255, 32'h0000_0000, 1'b0),
            known_row(8'd2, 8'd1, 32'h8040_2010, 1'b0),
            // 3 wide, height 0 read as 1: padded height 1 gives a zero step
            reg_row(CFG_SOURCE_WIDTH, 9'd3),
            reg_row(CFG_SOURCE_HEIGHT, 9'd0),
            reg_row(CFG_KEEP_ALPHA, 9'd1),
            store_row(16'h0001, 32'h00FF_00FF),
            store_row(16'h0002, 32'h1234_5678),
            compute_row(8'd0, 8'd0),
            compute_row(8'd1, 8'd0),
            compute_row(8'd2, 8'd0),
            compute_row(8'd3, 8'd0),
            known_row(8'd4, 8'd0, 32'h0000_0000, 1'b1),
            known_row(8'd0, 8'd1, 32'h0000_0000, 1'b1),
            known_row(8'd255, 8'd255, 32'h0000_0000, 1'b1),
            // sizes above the maximum clamp to 256
            reg_row(CFG_SOURCE_WIDTH, 9'd511),
            reg_row(CFG_SOURCE_HEIGHT, 9'd300),
            reg_row(CFG_KEEP_ALPHA, 9'd0),
            known_row(8'd255, 8'd255, 32'h0000_0000, 1'b0),
            // 1 x 1 image
            reg_row(CFG_SOURCE_WIDTH, 9'd1),
            reg_row(CFG_SOURCE_HEIGHT, 9'd1),
            known_row(8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0),
            known_row(8'd1, 8'd0, 32'h0000_0000, 1'b1),
            known_row(8'd0, 8'd1, 32'h0000_0000, 1'b1),
            // 2 x 3: east neighbours carry no weight, only north and south blend
            reg_row(CFG_SOURCE_WIDTH, 9'd2),
            reg_row(CFG_SOURCE_HEIGHT, 9'd3),
            reg_row(CFG_KEEP_ALPHA, 9'd1),
            store_row(16'h0003, 32'hA5A5_A5A5),
            store_row(16'h0004, 32'h0000_0000),
            store_row(16'h0005, 32'hFFFF_FFFF),
            compute_row(8'd1, 8'd1),
            compute_row(8'd0, 8'd3)
        };

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed rows
        sender_idle_pct = IDLE_PCT[0];
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CONFIG)
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            else
            begin
                known_valid = stim_rows[i].known;
                known_pix = stim_rows[i].known_pix;
                known_err = stim_rows[i].known_err;
                send_item(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].pix,
                          stim_rows[i].tx, stim_rows[i].ty);
            end
        end
        known_valid = 1'b0;

        // Random phases, each under its own register setting, with one idle rate for each group of four phases
        for (int p = 0; p < PHASES; p++)
        begin
            w_cfg = PHASE_W[p];
            h_cfg = PHASE_H[p];
            a_cfg = PHASE_A[p];
            if (p == RANDOM_PHASE)
            begin
                w_cfg = 9'($urandom_range(0, 511));
                h_cfg = 9'($urandom_range(0, 511));
                a_cfg = 1'($urandom);
            end
            write_reg(CFG_SOURCE_WIDTH, w_cfg);
            write_reg(CFG_SOURCE_HEIGHT, h_cfg);
            write_reg(CFG_KEEP_ALPHA, CFG_DATA_W'(a_cfg));
            sender_idle_pct = IDLE_PCT[p / 4];
            first_item = items_sent;
            while (items_sent - first_item < PHASE_ITEMS)
                random_item();
        end

        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hdl/bpr_pkg.sv
hdl/bpr_ram.sv
hdl/bpr_div.sv
hdl/bilinear_pow2_texture_resampler.sv
bench/tb_top.sv
